@@ rtl/matrix_vector_multiply_unit_assert.svh @@
// Assertion macros shared by the matrix-vector multiply modules.
`ifndef MATRIX_VECTOR_MULTIPLY_UNIT_ASSERT_SVH
`define MATRIX_VECTOR_MULTIPLY_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define MVM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property on every clock edge, reset included.
`define MVM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MVM_ASSERT(lbl, prop, msg)
`define MVM_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ rtl/mvm_pkg.sv @@
// Types and constants shared by the matrix-vector multiply modules.
package mvm_pkg;

  localparam int ACC_W      = 48;
  localparam int ROW_IDX_W  = 6;
  localparam int CFG_W      = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int OUT_DATA_W = ((ACC_W + ROW_IDX_W + 7) / 8) * 8;
  localparam int OUT_PAD_W  = OUT_DATA_W - ACC_W - ROW_IDX_W;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLUMNS = 1'b1;

  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_MATRIX = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC
  } mvm_state_t;

  typedef struct packed {
    logic vec_write;   // store the request value at the load position
    logic mem_read;    // read vector entry at the column position, capture value
    logic mul;         // register the product
    logic acc_step;    // accumulate, advance column, emit at row end
  } mvm_cmd_t;

  typedef struct packed {
    logic row_end;     // current column is the last of the row
    logic out_blocked; // output register full and not taken this cycle
  } mvm_sts_t;

endpackage

@@ rtl/mvm_ctrl.sv @@
// Controller state machine for the matrix-vector multiply unit.
`include "matrix_vector_multiply_unit_assert.svh"

module mvm_ctrl
  import mvm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  input  logic     in_action,
  output logic     in_tready,
  input  mvm_sts_t sts,
  output mvm_cmd_t cmd
);

  mvm_state_t state_r;
  mvm_state_t state_nxt;
  logic       accept;

  assign accept = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid && in_action == ACT_MATRIX) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        if (!(sts.row_end && sts.out_blocked)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready     = 1'b1;
        cmd.vec_write = in_tvalid && in_action == ACT_LOAD;
        cmd.mem_read  = in_tvalid && in_action == ACT_MATRIX;
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
      end
      ST_ACC: begin
        cmd.acc_step = !(sts.row_end && sts.out_blocked);
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  `MVM_ASSERT(a_matrix_to_mul, accept && in_action == ACT_MATRIX |=> state_r == ST_MUL, "matrix request did not start a multiply")
  `MVM_ASSERT(a_mul_to_acc, state_r == ST_MUL |=> state_r == ST_ACC, "multiply not followed by accumulate")
  `MVM_ASSERT(a_no_emit_blocked, cmd.acc_step && sts.row_end |-> !sts.out_blocked, "row sum emitted over a waiting result")

endmodule

@@ rtl/mvm_dpath.sv @@
// Datapath of the matrix-vector multiply unit: vector store, multiplier, accumulator.
`include "matrix_vector_multiply_unit_assert.svh"

module mvm_dpath
  import mvm_pkg::*;
#(
  parameter int MAX_DIM    = 64,
  parameter int ELEM_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata,
  input  logic [ELEM_WIDTH-1:0] in_value,
  input  mvm_cmd_t              cmd,
  output mvm_sts_t              sts,
  input  logic                  out_tready,
  output logic                  out_tvalid,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast
);

  localparam int IDX_W = $clog2(MAX_DIM);
  localparam int SZ_W  = $clog2(MAX_DIM + 1);
  localparam int CMP_W = (SZ_W > CFG_W) ? SZ_W : CFG_W;
  localparam int PRD_W = 2 * ELEM_WIDTH;

  logic [CFG_W-1:0]  rows_cfg_r, rows_cfg_nxt;
  logic [CFG_W-1:0]  cols_cfg_r, cols_cfg_nxt;
  logic [CMP_W-1:0]  rows_raw, cols_raw, rows_sz, cols_sz;
  logic [IDX_W-1:0]  last_row, last_col;

  logic [IDX_W-1:0]  load_pos_r, load_pos_nxt;
  logic [IDX_W-1:0]  col_pos_r, col_pos_nxt;
  logic [IDX_W-1:0]  row_pos_r, row_pos_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt, acc_sum;

  logic [ELEM_WIDTH-1:0] vec_mem [MAX_DIM];
  logic signed [ELEM_WIDTH-1:0] rdata_r;
  logic signed [ELEM_WIDTH-1:0] val_r;
  logic signed [PRD_W-1:0]      prod_r;

  logic                 out_valid_r, out_valid_nxt;
  logic [ACC_W-1:0]     out_sum_r;
  logic [ROW_IDX_W-1:0] out_idx_r;
  logic                 out_last_r;
  logic                 emit;

  // Clamp sizes: zero acts as one, anything above MAX_DIM saturates.
  always_comb begin
    rows_raw = CMP_W'(rows_cfg_r);
    cols_raw = CMP_W'(cols_cfg_r);
    if (rows_raw == '0) begin
      rows_sz = CMP_W'(1);
    end else if (rows_raw > CMP_W'(MAX_DIM)) begin
      rows_sz = CMP_W'(MAX_DIM);
    end else begin
      rows_sz = rows_raw;
    end
    if (cols_raw == '0) begin
      cols_sz = CMP_W'(1);
    end else if (cols_raw > CMP_W'(MAX_DIM)) begin
      cols_sz = CMP_W'(MAX_DIM);
    end else begin
      cols_sz = cols_raw;
    end
    last_row = IDX_W'(rows_sz - CMP_W'(1));
    last_col = IDX_W'(cols_sz - CMP_W'(1));
  end

  assign sts.row_end     = col_pos_r == last_col;
  assign sts.out_blocked = out_valid_r && !out_tready;
  assign emit            = cmd.acc_step && sts.row_end;
  assign acc_sum         = acc_r + ACC_W'(prod_r);

  always_comb begin
    rows_cfg_nxt  = rows_cfg_r;
    cols_cfg_nxt  = cols_cfg_r;
    load_pos_nxt  = load_pos_r;
    col_pos_nxt   = col_pos_r;
    row_pos_nxt   = row_pos_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r && !out_tready;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_NUM_ROWS:    rows_cfg_nxt = cfg_wdata;
        CFG_NUM_COLUMNS: cols_cfg_nxt = cfg_wdata;
        default:         rows_cfg_nxt = rows_cfg_r;
      endcase
      load_pos_nxt = '0;
      col_pos_nxt  = '0;
      row_pos_nxt  = '0;
      acc_nxt      = '0;
    end else begin
      if (cmd.vec_write) begin
        load_pos_nxt = (load_pos_r == last_col) ? '0 : load_pos_r + IDX_W'(1);
      end
      if (cmd.acc_step) begin
        if (sts.row_end) begin
          acc_nxt       = '0;
          col_pos_nxt   = '0;
          row_pos_nxt   = (row_pos_r == last_row) ? '0 : row_pos_r + IDX_W'(1);
          out_valid_nxt = 1'b1;
        end else begin
          acc_nxt     = acc_sum;
          col_pos_nxt = col_pos_r + IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_cfg_r  <= CFG_W'(1);
      cols_cfg_r  <= CFG_W'(1);
      load_pos_r  <= '0;
      col_pos_r   <= '0;
      row_pos_r   <= '0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rows_cfg_r  <= rows_cfg_nxt;
      cols_cfg_r  <= cols_cfg_nxt;
      load_pos_r  <= load_pos_nxt;
      col_pos_r   <= col_pos_nxt;
      row_pos_r   <= row_pos_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Vector store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.vec_write) begin
      vec_mem[load_pos_r] <= in_value;
    end
    if (cmd.mem_read) begin
      rdata_r <= vec_mem[col_pos_r];
      val_r   <= in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r <= val_r * rdata_r;
    end
    if (emit) begin
      out_sum_r  <= acc_sum;
      out_idx_r  <= ROW_IDX_W'(row_pos_r);
      out_last_r <= row_pos_r == last_row;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_idx_r, out_sum_r};
  assign out_tlast  = out_last_r;

  `MVM_ASSERT(a_col_in_range, CMP_W'(col_pos_r) < cols_sz, "column position beyond row length")
  `MVM_ASSERT(a_row_in_range, CMP_W'(row_pos_r) < rows_sz, "row position beyond row count")
  `MVM_ASSERT(a_cfg_clears, cfg_we |=> acc_r == '0 && col_pos_r == '0, "register write did not clear the positions")

endmodule

@@ rtl/matrix_vector_multiply_unit.sv @@
// Matrix-vector multiply unit top level: request and result channels, register port.
//
// Multiplies a matrix by a vector in signed Q8.8 fixed point, giving signed Q32.16 row
// sums in 48 bits that wrap modulo 2^48. Set num_rows (index 0) and num_columns
// (index 1) through the cfg port first; a value of zero acts as one and anything above
// MAX_DIM acts as MAX_DIM, and every register write restarts vector loading, row and
// column counting and clears the accumulator while keeping the stored vector. Then
// send requests on the in channel: tuser low loads the next vector element (the load
// position wraps after num_columns), tuser high supplies the next matrix element in
// row-major order. Load every vector entry before the matrix elements that use it;
// an entry never loaded gives an undefined sum. When a row's last column arrives, one
// result appears on the out channel with the sum and row index, and tlast marks the
// final row. Vector loads can stream back to back. A matrix element passes through the
// vector store read, the multiplier register and the accumulator before the next
// request is taken, and a row's final element also waits while an earlier result is
// still unclaimed on the out channel; the output register lets one finished result
// wait while the next row is computed.
module matrix_vector_multiply_unit
  import mvm_pkg::*;
#(
  parameter int MAX_DIM    = 64,
  parameter int ELEM_WIDTH = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // Register port
  input  logic                                  cfg_we,
  input  logic [CFG_IDX_W-1:0]                  cfg_index,
  input  logic [CFG_W-1:0]                      cfg_wdata,
  // Request channel
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [((ELEM_WIDTH + 7) / 8) * 8-1:0] in_tdata,  // [ELEM_WIDTH-1:0] value
  input  logic                                  in_tuser,  // [0] action
  // Result channel
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [OUT_DATA_W-1:0]                 out_tdata, // [47:0] row_sum, [53:48] row_index
  output logic                                  out_tlast  // final_row
);

  mvm_cmd_t cmd;
  mvm_sts_t sts;

  // Sequence each request: the controller steps, the datapath stores and computes.
  mvm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_action (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mvm_dpath #(
    .MAX_DIM    (MAX_DIM),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_value   (in_tdata[ELEM_WIDTH-1:0]),
    .cmd        (cmd),
    .sts        (sts),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

@@ sim/mvm_checker.sv @@
// Scoreboard for the matrix-vector multiply unit: row-sum predictor and result compare.
module mvm_checker
  import mvm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [15:0]           in_tdata,   // [15:0] value
  input  logic                  in_tuser,   // [0] action
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,  // [47:0] row_sum, [53:48] row_index
  input  logic                  out_tlast,  // final_row
  output int                    fail_count,
  output int                    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [ACC_W-1:0] row_sum;
    logic [ROW_IDX_W-1:0]    row_index;
    logic                    final_row;
  } row_result_t;

  row_result_t          expected_rows[$];
  logic signed [15:0]   vec_store [64];
  logic [CFG_W-1:0]     num_rows_q;
  logic [CFG_W-1:0]     num_cols_q;
  int                   load_ptr;
  int                   col_ptr;
  int                   row_ptr;
  logic [ACC_W-1:0]     acc;

  function automatic int clamp_dim(logic [CFG_W-1:0] raw);
    if (raw == 0) return 1;
    if (raw > 64) return 64;
    return int'(raw);
  endfunction

  task automatic clear_counters();
    load_ptr = 0;
    col_ptr  = 0;
    row_ptr  = 0;
    acc      = '0;
  endtask

  task automatic apply_element(logic act, logic [15:0] val);
    logic signed [15:0]      elem;
    logic signed [15:0]      vec;
    logic signed [ACC_W-1:0] prod;
    int                      cols;
    int                      rows;
    row_result_t             res;
    elem = val;
    cols = clamp_dim(num_cols_q);
    rows = clamp_dim(num_rows_q);
    if (act == ACT_LOAD) begin
      if (load_ptr >= cols) load_ptr = 0;
      vec_store[load_ptr] = elem;
      load_ptr++;
      if (load_ptr >= cols) load_ptr = 0;
    end else begin
      if (col_ptr >= cols) col_ptr = 0;
      if (row_ptr >= rows) row_ptr = 0;
      vec  = vec_store[col_ptr];
      prod = elem * vec;
      acc  = acc + prod;
      col_ptr++;
      if (col_ptr >= cols) begin
        res.row_sum   = acc;
        res.row_index = ROW_IDX_W'(row_ptr);
        res.final_row = (row_ptr + 1 == rows);
        expected_rows.insert(expected_rows.size(), res);
        col_ptr = 0;
        acc     = '0;
        row_ptr++;
        if (row_ptr >= rows) row_ptr = 0;
      end
    end
  endtask

  task automatic check_row();
    row_result_t             exp_row;
    logic signed [ACC_W-1:0] got_sum;
    logic [ROW_IDX_W-1:0]    got_index;
    got_sum   = out_tdata[ACC_W-1:0];
    got_index = out_tdata[ACC_W +: ROW_IDX_W];
    if (expected_rows.size() == 0) begin
      $error("out: result with no row pending (row_sum %0d, row_index %0d)", got_sum, got_index);
      fail_count++;
      return;
    end
    exp_row = expected_rows.pop_front();
    if (got_sum !== exp_row.row_sum) begin
      $error("row_sum: expected %0d, got %0d", exp_row.row_sum, got_sum);
      fail_count++;
    end
    if (got_index !== exp_row.row_index) begin
      $error("row_index: expected %0d, got %0d", exp_row.row_index, got_index);
      fail_count++;
    end
    if (out_tlast !== exp_row.final_row) begin
      $error("final_row: expected %0b, got %0b", exp_row.final_row, out_tlast);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      num_rows_q = 7'd1;
      num_cols_q = 7'd1;
      fail_count = 0;
      clear_counters();
    end else begin
      // Compare first: a result can never belong to a request taken on the same edge.
      if (out_tvalid && out_tready) check_row();
      if (cfg_we) begin
        if (cfg_index == CFG_NUM_ROWS) num_rows_q = cfg_wdata;
        else num_cols_q = cfg_wdata;
        clear_counters();
      end
      if (in_tvalid && in_tready) apply_element(in_tuser, in_tdata);
    end
    pending = expected_rows.size();
  end

endmodule

@@ sim/testbench.sv @@
// Top of the matrix-vector multiply unit testbench: clock, reset, stimulus and verdict.
module testbench;
  import mvm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TOTAL_REQUESTS = 950;
  localparam int CALM_TAIL      = 90;   // last requests run with no idling on either side
  localparam int DRAIN_CYCLES   = 6;    // drain margin for a matrix request still inside the block

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]      cfg_wdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [15:0]           in_tdata;   // [15:0] value
  logic                  in_tuser;   // [0] action
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // [47:0] row_sum, [53:48] row_index
  logic                  out_tlast;  // final_row

  int mismatches;
  int rows_pending;

  // Stimulus-side mirror of the block's sizes and pointers. It only serves to keep
  // matrix requests away from vector entries that were never loaded.
  int          rows_eff;
  int          cols_eff;
  int          next_load;
  int          next_col;
  logic [63:0] loaded;
  int          items_sent;

  matrix_vector_multiply_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  mvm_checker row_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .fail_count (mismatches),
    .pending    (rows_pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Hard stop in case a handshake never completes or a row sum never shows up.
  initial begin
    #5ms;
    $display("*** FAILED ***");
    $finish;
  end

  // Receiver: accept results, with random stall bursts until the calm tail.
  initial begin : result_sink
    int stall_left;
    out_tready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (items_sent < TOTAL_REQUESTS - CALM_TAIL && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 15);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  function automatic int clamp_dim(logic [CFG_W-1:0] raw);
    if (raw == 0) return 1;
    if (raw > 64) return 64;
    return int'(raw);
  endfunction

  // Mostly uniform values; now and then an extreme so the corner products recur.
  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 11))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'hFFFF;
      3:       return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Write one register; the block restarts its counters, so do the same in the mirror.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (idx == CFG_NUM_ROWS) rows_eff = clamp_dim(val);
    else cols_eff = clamp_dim(val);
    next_load = 0;
    next_col  = 0;
  endtask

  // Send one request, with an optional idle burst ahead of it; hold it until taken.
  task automatic push_request(logic act, logic [15:0] val);
    int gap;
    gap = 0;
    if (items_sent < TOTAL_REQUESTS - CALM_TAIL && $urandom_range(0, 5) == 0)
      gap = $urandom_range(1, 16);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= val;
    in_tuser  <= act;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    if (act == ACT_LOAD) begin
      loaded[next_load] = 1'b1;
      next_load++;
      if (next_load >= cols_eff) next_load = 0;
    end else begin
      next_col++;
      if (next_col >= cols_eff) next_col = 0;
    end
  endtask

  // Drop valid, wait for every pending row sum, then let any partial work finish.
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (rows_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // One random phase: new sizes, a vector load, then the matrix in row-major order.
  // Some phases stop mid-row so the next register write has to clear the partial sum;
  // a few stray loads land in the middle of the matrix stream.
  task automatic run_phase();
    logic [CFG_W-1:0] rows_raw;
    logic [CFG_W-1:0] cols_raw;
    int               passes;
    int               total;
    int               n_loads;
    rows_raw = CFG_W'($urandom_range(1, 8));
    cols_raw = CFG_W'($urandom_range(1, 8));
    case ($urandom_range(0, 9))
      0: begin
        rows_raw = $urandom_range(0, 1) ? 7'd64 : CFG_W'($urandom_range(65, 127));
        cols_raw = CFG_W'($urandom_range(0, 3));
      end
      1: begin
        cols_raw = $urandom_range(0, 1) ? 7'd64 : CFG_W'($urandom_range(65, 127));
        rows_raw = CFG_W'($urandom_range(0, 3));
      end
      2: rows_raw = '0;
      3: cols_raw = '0;
      default: ;
    endcase
    case ($urandom_range(0, 5))
      0: write_reg(CFG_NUM_ROWS, rows_raw);
      1: write_reg(CFG_NUM_COLUMNS, cols_raw);
      2: begin
        write_reg(CFG_NUM_COLUMNS, cols_raw);
        write_reg(CFG_NUM_ROWS, rows_raw);
      end
      default: begin
        write_reg(CFG_NUM_ROWS, rows_raw);
        write_reg(CFG_NUM_COLUMNS, cols_raw);
      end
    endcase
    // Keep the run short: never a large matrix in both directions.
    if (rows_eff * cols_eff > 256) write_reg(CFG_NUM_ROWS, CFG_W'($urandom_range(1, 3)));

    passes = (rows_eff * cols_eff <= 64) ? $urandom_range(1, 2) : 1;
    total  = rows_eff * cols_eff * passes;
    if ($urandom_range(0, 5) == 0) total = $urandom_range(0, total - 1);
    n_loads = ($urandom_range(0, 7) == 0) ? $urandom_range(0, cols_eff) : cols_eff;

    repeat (n_loads) push_request(ACT_LOAD, pick_value());
    repeat (total) begin
      if ($urandom_range(0, 15) == 0) push_request(ACT_LOAD, pick_value());
      while (!loaded[next_col]) push_request(ACT_LOAD, pick_value());
      push_request(ACT_MATRIX, pick_value());
    end
    settle();
  endtask

  initial begin
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = CFG_NUM_ROWS;
    cfg_wdata  = '0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = ACT_LOAD;
    rows_eff   = 1;
    cols_eff   = 1;
    next_load  = 0;
    next_col   = 0;
    loaded     = '0;
    items_sent = 0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // 2x3 with the extreme values: the largest positive and negative products.
    write_reg(CFG_NUM_ROWS, 7'd2);
    write_reg(CFG_NUM_COLUMNS, 7'd3);
    push_request(ACT_LOAD, 16'h7FFF);
    push_request(ACT_LOAD, 16'h8000);
    push_request(ACT_LOAD, 16'hFFFF);
    push_request(ACT_MATRIX, 16'h8000);
    push_request(ACT_MATRIX, 16'h8000);
    push_request(ACT_MATRIX, 16'h0001);
    push_request(ACT_MATRIX, 16'h7FFF);
    push_request(ACT_MATRIX, 16'h7FFF);
    push_request(ACT_MATRIX, 16'h8000);
    settle();

    // Zero sizes act as one: every matrix request closes a row and wraps the row count.
    write_reg(CFG_NUM_ROWS, 7'd0);
    write_reg(CFG_NUM_COLUMNS, 7'd0);
    push_request(ACT_LOAD, 16'h8000);
    push_request(ACT_MATRIX, 16'h8000);
    push_request(ACT_MATRIX, 16'h7FFF);
    push_request(ACT_MATRIX, 16'h0000);
    settle();

    // Loading wraps past the last column and overwrites entry zero; stop mid-row so
    // the next register write has a partial sum to clear.
    write_reg(CFG_NUM_ROWS, 7'd3);
    write_reg(CFG_NUM_COLUMNS, 7'd2);
    push_request(ACT_LOAD, 16'h0100);
    push_request(ACT_LOAD, 16'hFF00);
    push_request(ACT_LOAD, 16'h0200);
    push_request(ACT_MATRIX, 16'h1234);
    push_request(ACT_MATRIX, 16'hEDCC);
    push_request(ACT_MATRIX, 16'h4000);
    settle();

    // Out-of-range sizes saturate at the maximum dimension.
    write_reg(CFG_NUM_ROWS, 7'd1);
    write_reg(CFG_NUM_COLUMNS, 7'd127);
    repeat (64) push_request(ACT_LOAD, pick_value());
    repeat (64) push_request(ACT_MATRIX, pick_value());
    settle();

    while (items_sent < TOTAL_REQUESTS) run_phase();

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
